FILE: src/dwr_pkg.sv
package dwr_pkg;

   localparam int AVG_W  = 256;  // running average and decoded targets
   localparam int WORK_W = 280;  // product / quotient shift register
   localparam int MUL_W  = 23;   // small multiplier operand (act < 2^23)
   localparam int DIV_W  = 21;   // small divisor operand (tt < 2^21)

   localparam logic [30:0] FALLBACK_HEIGHT = 31'd24;
   // ceil(2^24 / 3): exact floor(x / 3) for x < 2^23
   localparam logic [23:0] RECIP3 = 24'd5592406;

   typedef struct packed {
      logic               start;
      logic [MUL_W-1:0]   m;
      logic [DIV_W-1:0]   d;
   } md_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } md_stat_type;

endpackage

FILE: src/dwr_muldiv.sv
// Bit-serial (a * m + b) / d. Multiply runs LSB first, one product bit a cycle,
// then restoring division MSB first, one quotient bit a cycle.
module dwr_muldiv (
   input  logic                        clock,
   input  logic                        reset,
   input  dwr_pkg::md_cmd_type         cmd,
   input  logic [dwr_pkg::AVG_W-1:0]   a_in,
   input  logic [dwr_pkg::AVG_W-1:0]   b_in,
   output dwr_pkg::md_stat_type        stat,
   output logic [dwr_pkg::WORK_W-1:0]  quo
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [8:0] LAST_STEP = 9'(dwr_pkg::WORK_W - 1);

   logic [1:0]                     state_ff, state_in;
   logic                           done_ff, done_in;
   logic [8:0]                     step_ff, step_in;
   logic [dwr_pkg::AVG_W-1:0]      a_ff, a_nx, b_ff, b_nx;
   logic [dwr_pkg::WORK_W-1:0]     work_ff, work_nx;
   logic [dwr_pkg::MUL_W-1:0]      m_ff, m_nx, carry_ff, carry_nx;
   logic [dwr_pkg::DIV_W-1:0]      d_ff, d_nx, rem_ff, rem_nx;
   logic [dwr_pkg::MUL_W:0]        prod;
   logic [dwr_pkg::DIV_W:0]        rem2, rem_diff;
   logic                           ge;

   always_comb begin
      prod = (a_ff[0] ? {1'b0, m_ff} : '0) + {{dwr_pkg::MUL_W{1'b0}}, b_ff[0]}
             + {1'b0, carry_ff};
      rem2 = {rem_ff, work_ff[dwr_pkg::WORK_W-1]};
      ge = rem2 >= {1'b0, d_ff};
      rem_diff = rem2 - {1'b0, d_ff};
   end

   always_comb begin
      state_in = state_ff;
      done_in = 1'b0;
      step_in = step_ff;
      a_nx = a_ff;
      b_nx = b_ff;
      work_nx = work_ff;
      m_nx = m_ff;
      d_nx = d_ff;
      carry_nx = carry_ff;
      rem_nx = rem_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               a_nx = a_in;
               b_nx = b_in;
               m_nx = cmd.m;
               d_nx = cmd.d;
               carry_nx = '0;
               rem_nx = '0;
               step_in = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            work_nx = {prod[0], work_ff[dwr_pkg::WORK_W-1:1]};
            carry_nx = prod[dwr_pkg::MUL_W:1];
            a_nx = {1'b0, a_ff[dwr_pkg::AVG_W-1:1]};
            b_nx = {1'b0, b_ff[dwr_pkg::AVG_W-1:1]};
            step_in = step_ff + 9'd1;
            if (step_ff == LAST_STEP) begin
               step_in = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            work_nx = {work_ff[dwr_pkg::WORK_W-2:0], ge};
            rem_nx = ge ? rem_diff[dwr_pkg::DIV_W-1:0] : rem2[dwr_pkg::DIV_W-1:0];
            step_in = step_ff + 9'd1;
            if (step_ff == LAST_STEP) begin
               state_in = S_IDLE;
               done_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      a_ff <= a_nx;
      b_ff <= b_nx;
      work_ff <= work_nx;
      m_ff <= m_nx;
      d_ff <= d_nx;
      carry_ff <= carry_nx;
      rem_ff <= rem_nx;
   end

   assign stat.busy = (state_ff != S_IDLE);
   assign stat.done = done_ff;
   assign quo = work_ff;

endmodule

FILE: src/difficulty_window_retarget.sv
// Channel  | Ports        | Contents
// req      | req_t*       | tdata: compact_bits, block_time, height; tlast: is_final
// rsp      | rsp_t*       | tdata: new_compact_bits; tuser: used_limit
// csr      | csr_*        | index 0 target_spacing, index 1 limit_compact
//
// One item at a time. A counted header runs the target decode, then the
// bit-serial multiply/divide (skipped for the first one). A final header adds
// the limit decode, a setup step, the multiply/divide (skipped on fallback) and
// compact normalization before the result register.
// Reset is synchronous; the window state returns to empty after each result.
// A waiting result does not block the next item; only a second result waits.
module difficulty_window_retarget #(
   parameter int WINDOW_BLOCKS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // compact_bits[31:0], block_time[63:32], height[94:64]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // new_compact_bits[31:0]
   output logic        rsp_tuser,   // used_limit[0]
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_HDEC = 4'd1;
   localparam logic [3:0] S_HMD  = 4'd2;
   localparam logic [3:0] S_FIN  = 4'd3;
   localparam logic [3:0] S_LDEC = 4'd4;
   localparam logic [3:0] S_ACT  = 4'd5;
   localparam logic [3:0] S_FMD  = 4'd6;
   localparam logic [3:0] S_ENC  = 4'd7;
   localparam logic [3:0] S_EMIT = 4'd8;

   localparam logic       IDX_SPACING = 1'b0;
   localparam logic       IDX_LIMIT   = 1'b1;
   localparam int         AW = dwr_pkg::AVG_W;

   logic [3:0]        state_ff, state_in;
   logic [15:0]       spacing_ff;
   logic [31:0]       limit_ff;
   logic [AW-1:0]     avg_ff, avg_in;
   logic [4:0]        count_ff, count_in;
   logic [31:0]       prev_ff, prev_in;
   logic [63:0]       ts_ff, ts_in;
   logic              closed_ff, closed_in;
   logic [31:0]       btime_ff, btime_in;
   logic              fin_ff, fin_in;
   logic [AW-1:0]     t_ff, t_in;
   logic [5:0]        shcnt_ff, shcnt_in;
   logic [20:0]       tt_ff, tt_in;
   logic [19:0]       lo_ff, lo_in;
   logic [22:0]       hi_ff, hi_in;
   logic [AW-1:0]     enc_ff, enc_in;
   logic [5:0]        size_ff, size_in;
   logic              used_ff, used_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_data_ff, rsp_data_in;
   logic              rsp_user_ff, rsp_user_in;

   dwr_pkg::md_cmd_type   md_cmd;
   dwr_pkg::md_stat_type  md_stat;
   logic [dwr_pkg::WORK_W-1:0] md_quo;
   logic [AW-1:0]         md_a, md_b;

   logic [31:0]   dec_bits;
   logic [7:0]    dec_size, dec_diff;
   logic [22:0]   dec_word;
   logic [AW-1:0] dec_t;
   logic [5:0]    dec_sh;
   logic [4:0]    cnt_new;
   logic [15:0]   sp_eff;
   logic [43:0]   lo_prod;
   logic [22:0]   act;
   logic [23:0]   mant;
   logic [7:0]    sz8;
   logic [31:0]   compact;
   logic          accept;
   logic          req_upd;

   dwr_muldiv u_md (
      .clock (clock),
      .reset (reset),
      .cmd   (md_cmd),
      .a_in  (md_a),
      .b_in  (md_b),
      .stat  (md_stat),
      .quo   (md_quo)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept = req_tvalid && req_tready;

   // compact decode setup; the byte shifts run in HDEC / LDEC
   always_comb begin
      dec_bits = (state_ff == S_IDLE) ? req_tdata[31:0] : limit_ff;
      dec_size = dec_bits[31:24];
      dec_word = dec_bits[22:0];
      dec_diff = dec_size - 8'd3;
      dec_t = '0;
      dec_sh = '0;
      if (dec_size <= 8'd3) begin
         unique case (dec_size[1:0])
            2'd0: dec_t = '0;
            2'd1: dec_t = {{(AW-23){1'b0}}, 16'b0, dec_word[22:16]};
            2'd2: dec_t = {{(AW-23){1'b0}}, 8'b0, dec_word[22:8]};
            2'd3: dec_t = {{(AW-23){1'b0}}, dec_word};
            default: dec_t = '0;
         endcase
      end else begin
         dec_t = {{(AW-23){1'b0}}, dec_word};
         dec_sh = (dec_diff > 8'd32) ? 6'd32 : dec_diff[5:0];
      end
   end

   always_comb begin
      cnt_new = count_ff + 5'd1;
      sp_eff = (spacing_ff == 16'd0) ? 16'd1 : spacing_ff;
      lo_prod = {23'b0, tt_ff} * {20'b0, dwr_pkg::RECIP3};
      if (ts_ff[63] || ts_ff < {44'b0, lo_ff}) begin
         act = {3'b0, lo_ff};
      end else if (ts_ff > {41'b0, hi_ff}) begin
         act = hi_ff;
      end else begin
         act = ts_ff[22:0];
      end
      req_upd = 1'b0;
      if (!closed_ff && !(count_ff == 5'd0 && req_tdata[94:64] < dwr_pkg::FALLBACK_HEIGHT)
          && req_tdata[94:64] != 31'd0) begin
         req_upd = 1'b1;
      end
      mant = enc_ff[AW-1:AW-24];
      sz8 = {2'b0, size_ff};
      if (mant[23]) begin
         compact = {sz8 + 8'd1, 8'b0, mant[23:8]};
      end else begin
         compact = {sz8, mant};
      end
   end

   always_comb begin
      state_in = state_ff;
      avg_in = avg_ff;
      count_in = count_ff;
      prev_in = prev_ff;
      ts_in = ts_ff;
      closed_in = closed_ff;
      btime_in = btime_ff;
      fin_in = fin_ff;
      t_in = t_ff;
      shcnt_in = shcnt_ff;
      tt_in = tt_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      enc_in = enc_ff;
      size_in = size_ff;
      used_in = used_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      md_cmd.start = 1'b0;
      md_cmd.m = {18'b0, cnt_new};
      md_cmd.d = {15'b0, {1'b0, cnt_new} + 6'd1};
      md_a = avg_ff;
      md_b = t_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               btime_in = req_tdata[63:32];
               fin_in = req_tlast;
               t_in = dec_t;
               shcnt_in = dec_sh;
               if (!closed_ff && !req_upd) begin
                  closed_in = 1'b1;
               end
               if (req_upd) begin
                  state_in = S_HDEC;
               end else if (req_tlast) begin
                  state_in = S_FIN;
               end
            end
         end
         S_HDEC: begin
            if (shcnt_ff != 6'd0) begin
               t_in = {t_ff[AW-9:0], 8'b0};
               shcnt_in = shcnt_ff - 6'd1;
            end else begin
               count_in = cnt_new;
               if (prev_ff != 32'd0) begin
                  ts_in = ts_ff + ({32'b0, prev_ff} - {32'b0, btime_ff});
               end
               prev_in = btime_ff;
               if (cnt_new >= 5'(WINDOW_BLOCKS)) begin
                  closed_in = 1'b1;
               end
               if (count_ff == 5'd0) begin
                  avg_in = t_ff;
                  state_in = fin_ff ? S_FIN : S_IDLE;
               end else begin
                  md_cmd.start = 1'b1;
                  state_in = S_HMD;
               end
            end
         end
         S_HMD: begin
            if (md_stat.done) begin
               avg_in = md_quo[AW-1:0];
               state_in = fin_ff ? S_FIN : S_IDLE;
            end
         end
         S_FIN: begin
            t_in = dec_t;
            shcnt_in = dec_sh;
            tt_in = {16'b0, count_ff} * {5'b0, sp_eff};
            state_in = S_LDEC;
         end
         S_LDEC: begin
            lo_in = lo_prod[43:24];
            hi_in = {2'b0, tt_ff} + {1'b0, tt_ff, 1'b0};
            if (shcnt_ff != 6'd0) begin
               t_in = {t_ff[AW-9:0], 8'b0};
               shcnt_in = shcnt_ff - 6'd1;
            end else begin
               state_in = S_ACT;
            end
         end
         S_ACT: begin
            if (count_ff == 5'd0) begin
               enc_in = t_ff;
               size_in = 6'd32;
               used_in = 1'b1;
               state_in = S_ENC;
            end else begin
               md_cmd.start = 1'b1;
               md_cmd.m = act;
               md_cmd.d = tt_ff;
               md_b = '0;
               state_in = S_FMD;
            end
         end
         S_FMD: begin
            if (md_stat.done) begin
               size_in = 6'd32;
               if (md_quo > {24'b0, t_ff}) begin
                  enc_in = t_ff;
                  used_in = 1'b1;
               end else begin
                  enc_in = md_quo[AW-1:0];
                  used_in = 1'b0;
               end
               state_in = S_ENC;
            end
         end
         S_ENC: begin
            // normalize so the top byte holds the most significant nonzero byte
            if (size_ff != 6'd0 && enc_ff[AW-1:AW-8] == 8'd0) begin
               enc_in = {enc_ff[AW-9:0], 8'b0};
               size_in = size_ff - 6'd1;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = compact;
               rsp_user_in = used_ff;
               avg_in = '0;
               count_in = '0;
               prev_in = '0;
               ts_in = '0;
               closed_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         spacing_ff <= 16'd60;
         limit_ff <= 32'd504365040;
         avg_ff <= '0;
         count_ff <= '0;
         prev_ff <= '0;
         ts_ff <= '0;
         closed_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         avg_ff <= avg_in;
         count_ff <= count_in;
         prev_ff <= prev_in;
         ts_ff <= ts_in;
         closed_ff <= closed_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               IDX_SPACING: spacing_ff <= csr_wdata[15:0];
               IDX_LIMIT:   limit_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      btime_ff <= btime_in;
      fin_ff <= fin_in;
      t_ff <= t_in;
      shcnt_ff <= shcnt_in;
      tt_ff <= tt_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      enc_ff <= enc_in;
      size_ff <= size_in;
      used_ff <= used_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

endmodule

FILE: src/dwr_checker.sv
module dwr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // encoder always leaves the mantissa sign bit clear
   a_mant_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[23])
      else $error("compact result has sign bit set");

   // a result never appears in the cycle right after a final item is taken
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !$rose(rsp_tvalid))
      else $error("result appeared too early");

endmodule

bind difficulty_window_retarget dwr_checker u_dwr_checker (.*);
